// ----- hdl/sti_pkg.sv -----
package sti_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

// ----- hdl/sti_cmd_if.sv -----
interface sti_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic        [sti_pkg::OPCODE_W-1:0]    opcode;
    logic signed [sti_pkg::DATA_WIDTH-1:0]  value;
    logic        [sti_pkg::INDEX_W-1:0]     index;

    modport source (output valid, output opcode, output value, output index, input ready);
    modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

// ----- hdl/sti_rsp_if.sv -----
interface sti_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic        [sti_pkg::STATUS_W-1:0]    status;
    logic signed [sti_pkg::DATA_WIDTH-1:0]  read_value;
    logic        [sti_pkg::COUNT_W-1:0]     count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// ----- hdl/sorted_table_insert_delete.sv -----
// Channel  Role    Payload                          Beat taken when
// cmd      sink    opcode, value, index             cmd.valid && cmd.ready
// rsp      source  status, read_value, count        rsp.valid && rsp.ready
//
// Each command is first registered, and then all sixteen compare-and-shift
// cells update the table together.
// A result waits in the output register; the next command is accepted while
// it waits, and is executed once that result beat leaves.
// Reset empties the table at once; there is no clearing pass.
module sorted_table_insert_delete
(
    input  logic      clk,
    input  logic      rst_n,
    sti_cmd_if.sink   cmd,
    sti_rsp_if.source rsp
);

    sti_pkg::ctl_cmd_t ctl;

    sti_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .ctl       (ctl)
    );

    sti_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .opcode     (cmd.opcode),
        .value      (cmd.value),
        .index      (cmd.index),
        .status     (rsp.status),
        .read_value (rsp.read_value),
        .count      (rsp.count)
    );

endmodule

// ----- hdl/sti_ctrl.sv -----
module sti_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output sti_pkg::ctl_cmd_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // The result register may be refilled in the same cycle its beat leaves.
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign ctl.load = cmd_valid && cmd_ready;
    assign ctl.exec = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hdl/sti_dp.sv -----
module sti_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sti_pkg::ctl_cmd_t                     ctl,
    input  logic        [sti_pkg::OPCODE_W-1:0]   opcode,
    input  logic signed [sti_pkg::DATA_WIDTH-1:0] value,
    input  logic        [sti_pkg::INDEX_W-1:0]    index,
    output logic        [sti_pkg::STATUS_W-1:0]   status,
    output logic signed [sti_pkg::DATA_WIDTH-1:0] read_value,
    output logic        [sti_pkg::COUNT_W-1:0]    count
);

    localparam int N = sti_pkg::CAPACITY;

    logic        [sti_pkg::OPCODE_W-1:0]   op_reg;
    logic signed [sti_pkg::DATA_WIDTH-1:0] value_reg;
    logic        [sti_pkg::INDEX_W-1:0]    index_reg;

    logic signed [sti_pkg::DATA_WIDTH-1:0] entries_reg [N];
    logic        [sti_pkg::COUNT_W-1:0]    count_reg;
    logic        [sti_pkg::COUNT_W-1:0]    count_next;

    logic        [sti_pkg::STATUS_W-1:0]   status_reg;
    logic        [sti_pkg::STATUS_W-1:0]   status_next;
    logic signed [sti_pkg::DATA_WIDTH-1:0] read_value_reg;
    logic signed [sti_pkg::DATA_WIDTH-1:0] read_value_next;

    logic [N-1:0] lt;
    logic [N-1:0] eq;
    logic [N-1:0] up_lt;
    logic signed [sti_pkg::DATA_WIDTH-1:0] up_e   [N];
    logic signed [sti_pkg::DATA_WIDTH-1:0] down_e [N];
    logic signed [sti_pkg::DATA_WIDTH-1:0] ins_e  [N];
    logic signed [sti_pkg::DATA_WIDTH-1:0] del_e  [N];

    logic full;
    logic found;
    logic do_insert;
    logic do_delete;

    // Each cell compares its own entry against the operand; only cells below
    // the fill count take part. The table is sorted, so lt is a prefix.
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic in_use;
            assign in_use = (sti_pkg::COUNT_W'(g) < count_reg);
            assign lt[g]  = in_use && (entries_reg[g] < value_reg);
            assign eq[g]  = in_use && (entries_reg[g] == value_reg);

            if (g == 0)
            begin : g_first
                assign up_lt[g] = 1'b1;
                assign up_e[g]  = value_reg;
            end
            else
            begin : g_rest
                assign up_lt[g] = lt[g-1];
                assign up_e[g]  = entries_reg[g-1];
            end

            if (g == N - 1)
            begin : g_last
                assign down_e[g] = entries_reg[g];
            end
            else
            begin : g_inner
                assign down_e[g] = entries_reg[g+1];
            end

            // Insert: keep smaller entries, drop the operand at the first
            // cell that is not smaller, shift the rest up by one.
            assign ins_e[g] = lt[g] ? entries_reg[g] : (up_lt[g] ? value_reg : up_e[g]);
            // Delete: the first equal entry sits right after the smaller ones.
            assign del_e[g] = lt[g] ? entries_reg[g] : down_e[g];
        end
    endgenerate

    assign full  = (count_reg == sti_pkg::COUNT_W'(N));
    assign found = |eq;

    always_comb
    begin
        status_next     = sti_pkg::ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        do_insert       = 1'b0;
        do_delete       = 1'b0;
        unique case (op_reg)
            sti_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = sti_pkg::ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + sti_pkg::COUNT_W'(1);
                end
            end
            sti_pkg::OP_DELETE:
            begin
                if (!found)
                begin
                    status_next = sti_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    do_delete  = 1'b1;
                    count_next = count_reg - sti_pkg::COUNT_W'(1);
                end
            end
            sti_pkg::OP_READ:
            begin
                if (sti_pkg::COUNT_W'(index_reg) >= count_reg)
                begin
                    status_next = sti_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    read_value_next = entries_reg[index_reg];
                end
            end
            default:
            begin
                status_next = sti_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= opcode;
            value_reg <= value;
            index_reg <= index;
        end
        if (ctl.exec)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            for (int i = 0; i < N; i++)
            begin
                if (do_insert)
                begin
                    entries_reg[i] <= ins_e[i];
                end
                else if (do_delete)
                begin
                    entries_reg[i] <= del_e[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;

endmodule

// ----- bench/sorted_table_insert_delete_tb.sv -----
`timescale 1ns / 100ps

module sorted_table_insert_delete_tb;
    import sti_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int MAX_GAP        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int EPOCHS         = 25;
    localparam int EPOCH_LEN      = 41;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        status_t            status;
        word_t              read_value;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        word_t               value;
        logic [INDEX_W-1:0]  index;
        logic                pinned;
        result_t             want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sti_cmd_if cmd ();
    sti_rsp_if rsp ();

    sorted_table_insert_delete dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    // Shadow copy of the table, kept in ascending order.
    word_t   shadow[$];
    result_t pending_results[$];
    step_t   directed[$];

    bit send_burst;
    bit rsp_burst;
    int errors;
    int cmd_beats;
    int rsp_beats;
    int n_ok;
    int n_not_found;
    int n_full;
    int n_bad_index;
    int full_hits;
    int empty_hits;

    function automatic result_t apply_to_shadow(input logic [OPCODE_W-1:0] op, input word_t v,
                                                input logic [INDEX_W-1:0] ix);
        result_t r;
        int      pos;
        r.status     = ST_OK;
        r.read_value = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow.size() && shadow[pos] < v)
                        pos++;
                    shadow.insert(pos, v);
                end
            end
            OP_DELETE:
            begin
                pos = 0;
                while (pos < shadow.size() && shadow[pos] != v)
                    pos++;
                if (pos >= shadow.size())
                    r.status = ST_NOT_FOUND;
                else
                    shadow.delete(pos);
            end
            OP_READ:
            begin
                if (int'(ix) >= shadow.size())
                    r.status = ST_BAD_INDEX;
                else
                    r.read_value = shadow[ix];
            end
            default: ;
        endcase
        r.count = COUNT_W'(shadow.size());
        return r;
    endfunction

    function automatic word_t draw_value();
        word_t v;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0001;
                    5: v = 32'h8000_0001;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end
            // A narrow band around zero makes duplicates common.
            1: v = word_t'($urandom_range(0, 8)) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic step_t draw_step(input int mode);
        step_t s;
        int    pick;
        int    ins_pct;
        int    del_pct;
        s       = '0;
        s.index = INDEX_W'($urandom_range(0, 15));
        s.value = draw_value();
        case (mode)
            MODE_FILL:
            begin
                ins_pct = 60;
                del_pct = 15;
            end
            MODE_DRAIN:
            begin
                ins_pct = 15;
                del_pct = 60;
            end
            default:
            begin
                ins_pct = 35;
                del_pct = 35;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 3)
            s.opcode = OP_UNUSED;
        else if (pick < 3 + ins_pct)
            s.opcode = OP_INSERT;
        else if (pick < 3 + ins_pct + del_pct)
        begin
            s.opcode = OP_DELETE;
            if (shadow.size() != 0 && $urandom_range(0, 3) != 0)
                s.value = shadow[$urandom_range(0, shadow.size() - 1)];
        end
        else
        begin
            s.opcode = OP_READ;
            if (shadow.size() != 0 && $urandom_range(0, 3) != 0)
                s.index = INDEX_W'($urandom_range(0, shadow.size() - 1));
        end
        return s;
    endfunction

    task automatic add_row(input logic [OPCODE_W-1:0] op, input word_t v,
                           input logic [INDEX_W-1:0] ix, input logic pinned,
                           input status_t st, input word_t rd, input logic [COUNT_W-1:0] cnt);
        step_t s;
        s.opcode          = op;
        s.value           = v;
        s.index           = ix;
        s.pinned          = pinned;
        s.want.status     = st;
        s.want.read_value = rd;
        s.want.count      = cnt;
        directed.push_back(s);
    endtask

    // The shadow table moves at the command beat, so the next command is always
    // drawn against the table as it will be when that command executes.
    task automatic send_cmd(input step_t s);
        int      gap;
        result_t r;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid  <= 1'b1;
        cmd.opcode <= s.opcode;
        cmd.value  <= s.value;
        cmd.index  <= s.index;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        r = apply_to_shadow(s.opcode, s.value, s.index);
        pending_results.push_back(s.pinned ? s.want : r);
        cmd_beats++;
    endtask

    task automatic hold_off_until_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_side
        result_t due;
        int      hold;
        if (rsp.valid && rsp.ready)
        begin
            rsp_beats++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (status %0d %s",
                         $time, rsp.status,
                         $sformatf("read_value %0d count %0d)", rsp.read_value, rsp.count));
                errors++;
            end
            else
            begin
                due = pending_results.pop_front();
                if (rsp.status !== due.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, due.status, rsp.status);
                    errors++;
                end
                if (rsp.read_value !== due.read_value)
                begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, due.read_value, rsp.read_value);
                    errors++;
                end
                if (rsp.count !== due.count)
                begin
                    $display("%0t: count expected %0d, got %0d", $time, due.count, rsp.count);
                    errors++;
                end
                case (due.status)
                    ST_OK:        n_ok++;
                    ST_NOT_FOUND: n_not_found++;
                    ST_FULL:      n_full++;
                    default:      n_bad_index++;
                endcase
                if (due.count == CAPACITY)
                    full_hits++;
                if (due.count == 0)
                    empty_hits++;
            end
            hold = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        else if (hold > 0)
            hold--;
        rsp.ready <= (hold == 0);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[sorted_table_insert_delete] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int ep;
        int k;
        int mode;
        cmd.valid  = 1'b0;
        cmd.opcode = OP_INSERT;
        cmd.value  = '0;
        cmd.index  = '0;
        send_burst = 1'b0;
        rsp_burst  = 1'b0;

        // Empty table, unused opcode, extremes, duplicates, filling to capacity, then reads and deletes.
        add_row(OP_READ,   32'h0000_0000, 4'd0,  1'b1, ST_BAD_INDEX, 32'h0, 5'd0);
        add_row(OP_DELETE, 32'hFFFF_FFFF, 4'd0,  1'b1, ST_NOT_FOUND, 32'h0, 5'd0);
        add_row(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1, ST_OK,        32'h0, 5'd0);
        add_row(OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0001, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h5555_5555, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'hAAAA_AAAA, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h00FF_00FF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'hFF00_FF00, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h1234_5678, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h8765_4321, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h7FFF_FFFE, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h8000_0001, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1'b1, ST_FULL,      32'h0, 5'd16);
        add_row(OP_READ,   32'h0000_0000, 4'd0,  1'b1, ST_OK,        32'h8000_0000, 5'd16);
        add_row(OP_READ,   32'h0000_0000, 4'd15, 1'b1, ST_OK,        32'h7FFF_FFFF, 5'd16);
        add_row(OP_DELETE, 32'h7FFF_FFFF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        add_row(OP_READ,   32'h0000_0000, 4'd15, 1'b1, ST_BAD_INDEX, 32'h0, 5'd15);
        add_row(OP_DELETE, 32'h7FFF_FFFF, 4'd0,  1'b0, ST_OK, 32'h0, 5'd0);
        // Now above every stored value.
        add_row(OP_DELETE, 32'h7FFF_FFFF, 4'd0,  1'b1, ST_NOT_FOUND, 32'h0, 5'd14);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_cmd(directed[i]);
        hold_off_until_drained();

        for (ep = 0; ep < EPOCHS; ep++)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
            rsp_burst  = ($urandom_range(0, 3) == 0);
            case (ep % 4)
                0, 1:    mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            if ($urandom_range(0, 4) == 0)
                mode = MODE_MIXED;
            for (k = 0; k < EPOCH_LEN; k++)
                send_cmd(draw_step(mode));
            if (ep % 6 == 5)
                hold_off_until_drained();
        end

        cmd.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands, checked %0d results: %0d ok, %0d not found, %s",
                 cmd_beats, rsp_beats, n_ok, n_not_found,
                 $sformatf("%0d full, %0d bad index.", n_full, n_bad_index));
        $display("The table stood at capacity after %0d results and empty after %0d.",
                 full_hits, empty_hits);
        if (errors == 0)
            $display("[sorted_table_insert_delete] OK");
        else
            $display("[sorted_table_insert_delete] ERROR");
        $finish;
    end

endmodule
